// ===== rtl/mcst_pkg.sv =====
`default_nettype none

package mcst_pkg;

  // default table size
  localparam int TimerSlotsDef = 16;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_KILL    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  // result kind and status codes
  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // input item
  typedef struct packed {
    cmd_t        command;
    logic [31:0] now_ms;
    logic [31:0] timeout_ms;
    logic        periodic_mode;
    logic [3:0]  slot_id;
    logic        has_action;
    logic [15:0] action_tag;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        result_kind;
    logic        status;
    logic [3:0]  slot_out;
    logic [15:0] tag_out;
    logic        last;
  } out_item_t;

  // per-slot settings held in one memory word
  typedef struct packed {
    logic [31:0] timeout_ms;
    logic        periodic;
    logic        has_action;
    logic [15:0] tag;
  } slot_cfg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CREATE,
    ST_KILL_RD,
    ST_KILL_WR,
    ST_TICK_ORD,
    ST_TICK_SLOT,
    ST_TICK_EVAL,
    ST_TICK_ACT,
    ST_WALK_END,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic scan_clr;
    logic scan_inc;
    logic create_wr;
    logic kill_clr;
    logic restart_wr;
    logic walk_clr;
    logic ord_rd;
    logic kill_step;
    logic tick_slot;
    logic tick_eval;
    logic tick_step;
    logic walk_end;
    logic emit_done;
    logic done_err;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t command;
    logic sid_ok;
    logic scan_free;
    logic scan_end;
    logic count_zero;
    logic walk_last;
    logic fire_act;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mcst_ram.sv =====
`default_nettype none

module mcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/mcst_ctrl.sv =====
`default_nettype none

module mcst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mcst_pkg::dp_sts_t sts,
  output mcst_pkg::ctl_cmd_t     cmd
);

  import mcst_pkg::*;

  state_t state_r, state_nxt;
  logic   err_r, err_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    err_nxt      = err_r;
    cmd          = '0;
    cmd.done_err = err_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.command)
          CMD_CREATE: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
          CMD_KILL: begin
            err_nxt = !sts.sid_ok;
            if (sts.sid_ok) begin
              cmd.kill_clr = 1'b1;
              cmd.walk_clr = 1'b1;
              state_nxt    = ST_KILL_RD;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          CMD_RESTART: begin
            err_nxt        = !sts.sid_ok;
            cmd.restart_wr = sts.sid_ok;
            state_nxt      = ST_DONE;
          end
          default: begin
            err_nxt      = 1'b0;
            cmd.walk_clr = 1'b1;
            state_nxt    = sts.count_zero ? ST_DONE : ST_TICK_ORD;
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          err_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (sts.scan_free) begin
          state_nxt = ST_CREATE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_CREATE: begin
        cmd.create_wr = 1'b1;
        err_nxt       = 1'b0;
        state_nxt     = ST_DONE;
      end
      // kill: compact the creation order without the killed slot
      ST_KILL_RD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = ST_KILL_WR;
      end
      ST_KILL_WR: begin
        cmd.kill_step = 1'b1;
        state_nxt     = sts.walk_last ? ST_WALK_END : ST_KILL_RD;
      end
      // tick: one live timer per pass
      ST_TICK_ORD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = ST_TICK_SLOT;
      end
      ST_TICK_SLOT: begin
        cmd.tick_slot = 1'b1;
        state_nxt     = ST_TICK_EVAL;
      end
      ST_TICK_EVAL: begin
        cmd.tick_eval = 1'b1;
        state_nxt     = ST_TICK_ACT;
      end
      ST_TICK_ACT: begin
        if (!sts.fire_act || sts.out_free) begin
          cmd.tick_step = 1'b1;
          state_nxt     = sts.walk_last ? ST_WALK_END : ST_TICK_ORD;
        end
      end
      ST_WALK_END: begin
        cmd.walk_end = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mcst_dp.sv =====
`default_nettype none

module mcst_dp #(
  parameter int TIMER_SLOTS = mcst_pkg::TimerSlotsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mcst_pkg::in_item_t in_item,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output mcst_pkg::out_item_t     out_item,
  input  wire mcst_pkg::ctl_cmd_t cmd,
  output mcst_pkg::dp_sts_t       sts
);

  import mcst_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  in_item_t               item_r;
  logic [31:0]            time_max_r;
  logic [TIMER_SLOTS-1:0] live_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          i_r;
  logic [CW-1:0]          w_r;
  logic [CW-1:0]          j_r;
  logic [SW-1:0]          s_r;
  logic [31:0]            elapsed_r;
  logic [31:0]            elapsed_nxt;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic [SW-1:0] i_idx, j_idx, sid_idx;
  logic          sid_in_range;
  logic          fire, keep, kill_keep, fire_act;
  logic          out_free;

  logic          ord_we;
  logic [SW-1:0] ord_waddr, ord_wdata, ord_rdata;
  logic          start_we;
  logic [SW-1:0] start_waddr;
  logic [31:0]   start_rdata;
  slot_cfg_t     prm_wdata, prm_rdata;

  assign i_idx   = i_r[SW-1:0];
  assign j_idx   = j_r[SW-1:0];
  assign sid_idx = SW'(item_r.slot_id);
  assign sid_in_range = (CW + 4)'(item_r.slot_id) < (CW + 4)'(TIMER_SLOTS);

  // expiry decision for the slot under evaluation
  assign fire      = elapsed_r >= prm_rdata.timeout_ms;
  assign keep      = !fire || prm_rdata.periodic;
  assign fire_act  = fire && prm_rdata.has_action;
  assign kill_keep = ord_rdata != sid_idx;
  assign out_free  = !out_valid_r || out_ready;

  // elapsed time with clock wraparound
  always_comb begin
    if (item_r.now_ms >= start_rdata) begin
      elapsed_nxt = item_r.now_ms - start_rdata;
    end else begin
      elapsed_nxt = time_max_r - start_rdata + item_r.now_ms;
    end
  end

  // status to controller
  always_comb begin
    sts            = '0;
    sts.command    = item_r.command;
    sts.sid_ok     = sid_in_range && live_r[sid_idx];
    sts.scan_end   = j_r == CW'(TIMER_SLOTS);
    sts.scan_free  = !sts.scan_end && !live_r[j_idx];
    sts.count_zero = count_r == '0;
    sts.walk_last  = (i_r + CW'(1)) == count_r;
    sts.fire_act   = fire_act;
    sts.out_free   = out_free;
  end

  // creation order memory
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = w_r[SW-1:0];
    ord_wdata = ord_rdata;
    if (cmd.create_wr) begin
      ord_we    = 1'b1;
      ord_waddr = count_r[SW-1:0];
      ord_wdata = j_idx;
    end else if (cmd.kill_step) begin
      ord_we = kill_keep;
    end else if (cmd.tick_step) begin
      ord_we    = keep;
      ord_wdata = s_r;
    end
  end

  mcst_ram #(.WIDTH(SW), .DEPTH(TIMER_SLOTS)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .re    (cmd.ord_rd),
    .raddr (i_idx),
    .rdata (ord_rdata)
  );

  // start time memory
  always_comb begin
    start_we    = 1'b0;
    start_waddr = s_r;
    if (cmd.create_wr) begin
      start_we    = 1'b1;
      start_waddr = j_idx;
    end else if (cmd.restart_wr) begin
      start_we    = 1'b1;
      start_waddr = sid_idx;
    end else if (cmd.tick_step) begin
      start_we = fire && prm_rdata.periodic;
    end
  end

  mcst_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (start_waddr),
    .wdata (item_r.now_ms),
    .re    (cmd.tick_slot),
    .raddr (ord_rdata),
    .rdata (start_rdata)
  );

  // timeout, mode and tag memory
  always_comb begin
    prm_wdata            = '0;
    prm_wdata.timeout_ms = item_r.timeout_ms;
    prm_wdata.periodic   = item_r.periodic_mode;
    prm_wdata.has_action = item_r.has_action;
    prm_wdata.tag        = item_r.action_tag;
  end

  mcst_ram #(.WIDTH($bits(slot_cfg_t)), .DEPTH(TIMER_SLOTS)) u_cfg_ram (
    .clk   (clk),
    .we    (cmd.create_wr),
    .waddr (j_idx),
    .wdata (prm_wdata),
    .re    (cmd.tick_slot),
    .raddr (ord_rdata),
    .rdata (prm_rdata)
  );

  // item capture and per-timer payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.tick_slot) begin
      s_r <= ord_rdata;
    end
    if (cmd.tick_eval) begin
      elapsed_r <= elapsed_nxt;
    end
  end

  // time_max register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_max_r <= '1;
    end else if (cfg_we) begin
      time_max_r <= cfg_wdata;
    end
  end

  // live bits, live count and walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      count_r <= '0;
      i_r     <= '0;
      w_r     <= '0;
      j_r     <= '0;
    end else begin
      if (cmd.scan_clr) begin
        j_r <= '0;
      end else if (cmd.scan_inc) begin
        j_r <= j_r + CW'(1);
      end
      if (cmd.create_wr) begin
        live_r[j_idx] <= 1'b1;
        count_r       <= count_r + CW'(1);
      end
      if (cmd.kill_clr) begin
        live_r[sid_idx] <= 1'b0;
      end
      if (cmd.walk_clr) begin
        i_r <= '0;
        w_r <= '0;
      end
      if (cmd.kill_step) begin
        i_r <= i_r + CW'(1);
        w_r <= w_r + CW'(kill_keep);
      end
      if (cmd.tick_step) begin
        i_r <= i_r + CW'(1);
        w_r <= w_r + CW'(keep);
        if (!keep) begin
          live_r[s_r] <= 1'b0;
        end
      end
      if (cmd.walk_end) begin
        count_r <= w_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_done || (cmd.tick_step && fire_act)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step && fire_act) begin
      out_r.result_kind <= KIND_FIRE;
      out_r.status      <= STATUS_OK;
      out_r.slot_out    <= 4'(s_r);
      out_r.tag_out     <= prm_rdata.tag;
      out_r.last        <= 1'b0;
    end else if (cmd.emit_done) begin
      out_r.result_kind <= KIND_DONE;
      out_r.status      <= cmd.done_err ? STATUS_ERR : STATUS_OK;
      out_r.tag_out     <= '0;
      out_r.last        <= 1'b1;
      case (item_r.command)
        CMD_CREATE:  out_r.slot_out <= cmd.done_err ? 4'd0 : 4'(j_r);
        CMD_TICK:    out_r.slot_out <= 4'd0;
        default:     out_r.slot_out <= item_r.slot_id;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== rtl/multi_channel_soft_timer_table_core.sv =====
// Timer table with up to TIMER_SLOTS software timers.
// Input channel (in_valid/in_ready/in_item): one command item at a time:
// create, kill, restart or tick. Result channel (out_valid/out_ready/out_item):
// every item ends with one completion result with last set; a tick first
// sends one fired event per expiring timer that has an action, in creation
// order. The user must write time_max (cfg_we/cfg_wdata) only while the
// block is idle; the block itself does not enforce it. A create takes the
// lowest free slot. The per-timer steps are the registered reads of the
// creation order memory and then of the slot memories, followed by the
// elapsed time and the compare. Items are handled one at a time; a new
// item is taken as soon as the previous completion sits in the output
// register.
// Reset empties the table and sets time_max to all ones; no clearing pass.
// A stalled receiver holds the result register and pauses a tick walk at
// the next fired event; nothing is dropped.
`default_nettype none

module multi_channel_soft_timer_table_core #(
  parameter int TIMER_SLOTS = mcst_pkg::TimerSlotsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mcst_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mcst_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata
);

  import mcst_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencing
  mcst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table storage and arithmetic
  mcst_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  import mcst_pkg::*;

  localparam int NumSlots = TimerSlotsDef;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // command items waiting for the driver, results still owed by the block
  in_item_t  cmd_backlog[$];
  out_item_t timer_results_due[$];

  // shadow copy of the timer table
  logic [31:0] tm_max = 32'hFFFF_FFFF;
  bit          tm_live[NumSlots];
  bit          tm_periodic[NumSlots];
  logic [31:0] tm_start[NumSlots];
  logic [31:0] tm_timeout[NumSlots];
  bit          tm_has_act[NumSlots];
  logic [15:0] tm_tag[NumSlots];
  int          tm_order[NumSlots];
  int          tm_count = 0;

  int          err_count = 0;
  int unsigned cyc = 0;
  logic [31:0] gen_now = '0;
  logic        calm;

  multi_channel_soft_timer_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // long stretch with no idling on either side
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end
  assign calm = (cyc % 6000) >= 4000;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    end
  endtask

  // apply one accepted command item to the shadow table, queue its results
  task automatic run_timer_command(input in_item_t it);
    int          i;
    int          w;
    int          s;
    logic [31:0] el;
    bit          keep;
    out_item_t   r;
    r = '0;
    r.result_kind = KIND_DONE;
    r.status = STATUS_OK;
    r.last = 1'b1;
    case (it.command)
      CMD_CREATE: begin
        s = -1;
        for (i = NumSlots - 1; i >= 0; i--) begin
          if (!tm_live[i]) s = i;
        end
        if (s < 0 || tm_count >= NumSlots) begin
          r.status = STATUS_ERR;
        end else begin
          tm_live[s] = 1'b1;
          tm_periodic[s] = it.periodic_mode;
          tm_start[s] = it.now_ms;
          tm_timeout[s] = it.timeout_ms;
          tm_has_act[s] = it.has_action;
          tm_tag[s] = it.action_tag;
          tm_order[tm_count] = s;
          tm_count++;
          r.slot_out = 4'(s);
        end
      end
      CMD_KILL, CMD_RESTART: begin
        r.slot_out = it.slot_id;
        if (!tm_live[it.slot_id]) begin
          r.status = STATUS_ERR;
        end else if (it.command == CMD_KILL) begin
          tm_live[it.slot_id] = 1'b0;
          w = 0;
          for (i = 0; i < tm_count; i++) begin
            if (tm_order[i] != int'(it.slot_id)) begin
              tm_order[w] = tm_order[i];
              w++;
            end
          end
          tm_count = w;
        end else begin
          tm_start[it.slot_id] = it.now_ms;
        end
      end
      default: begin
        // tick: walk live timers in creation order
        w = 0;
        for (i = 0; i < tm_count; i++) begin
          s = tm_order[i];
          if (it.now_ms >= tm_start[s]) el = it.now_ms - tm_start[s];
          else el = tm_max - tm_start[s] + it.now_ms;
          keep = 1'b1;
          if (el >= tm_timeout[s]) begin
            if (tm_has_act[s]) begin
              timer_results_due.push_back('{KIND_FIRE, STATUS_OK, 4'(s), tm_tag[s], 1'b0});
            end
            if (tm_periodic[s]) begin
              tm_start[s] = it.now_ms;
            end else begin
              tm_live[s] = 1'b0;
              keep = 1'b0;
            end
          end
          if (keep) begin
            tm_order[w] = s;
            w++;
          end
        end
        tm_count = w;
      end
    endcase
    timer_results_due.push_back(r);
  endtask

  task automatic push_cmd(input cmd_t c, input logic [31:0] now, input logic [31:0] tmo,
                          input bit per, input logic [3:0] sid, input bit act,
                          input logic [15:0] tag);
    in_item_t it;
    it.command = c;
    it.now_ms = now;
    it.timeout_ms = tmo;
    it.periodic_mode = per;
    it.slot_id = sid;
    it.has_action = act;
    it.action_tag = tag;
    cmd_backlog.push_back(it);
  endtask

  // random commands on a clock that advances and wraps at time_max
  task automatic queue_random_cmds(input int n);
    int          k;
    int          roll;
    longint      nxt;
    logic [31:0] tmo;
    logic [3:0]  sid;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) nxt = longint'(gen_now) + $urandom_range(0, 400);
      else nxt = longint'(gen_now) + $urandom_range(0, 12);
      gen_now = 32'(nxt % (longint'(tm_max) + 1));
      roll = $urandom_range(0, 99);
      tmo = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
      sid = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
      if (roll < 8) begin
        // noise: every field random
        push_cmd(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom),
                 4'($urandom), 1'($urandom), 16'($urandom));
      end else if (roll < 36) begin
        push_cmd(CMD_CREATE, gen_now, tmo, $urandom_range(0, 99) < 35, sid,
                 $urandom_range(0, 3) != 0, 16'($urandom));
      end else if (roll < 50) begin
        push_cmd(CMD_KILL, gen_now, tmo, 1'($urandom), sid, 1'($urandom), 16'($urandom));
      end else if (roll < 62) begin
        push_cmd(CMD_RESTART, gen_now, tmo, 1'($urandom), sid, 1'($urandom), 16'($urandom));
      end else begin
        push_cmd(CMD_TICK, gen_now, tmo, 1'($urandom), sid, 1'($urandom), 16'($urandom));
      end
    end
  endtask

  // block idle: nothing queued, nothing in flight, no result owed
  task automatic wait_quiet();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || timer_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_time_max(input logic [31:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tm_max = v;
  endtask

  // driver: present queued items, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) run_timer_command(in_item);
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          in_item <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls, compare each result with the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (timer_results_due.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_item), 32'd0);
        end else begin
          want = timer_results_due.pop_front();
          if (out_item.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(out_item.result_kind), 32'(want.result_kind));
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.slot_out !== want.slot_out)
            report_mismatch("slot_out", 32'(out_item.slot_out), 32'(want.slot_out));
          if (out_item.tag_out !== want.tag_out)
            report_mismatch("tag_out", 32'(out_item.tag_out), 32'(want.tag_out));
          if (out_item.last !== want.last)
            report_mismatch("last", 32'(out_item.last), 32'(want.last));
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  // stimulus
  initial begin
    int          i;
    logic [31:0] tmax_set[4];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, errors on dead slots, fill up, full, wraparound
    push_cmd(CMD_TICK, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0, 16'd0);
    push_cmd(CMD_KILL, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0, 16'd0);
    push_cmd(CMD_RESTART, 32'd5, 32'd0, 1'b1, 4'd15, 1'b1, 16'hFFFF);
    for (i = 0; i < NumSlots; i++) begin
      push_cmd(CMD_CREATE, (i < 8) ? 32'hFFFF_FFF0 + 32'(i) : 32'(i),
               (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : 32'(i * 3),
               i[0], 4'($urandom), (i % 4) != 3,
               (i == 2) ? 16'hFFFF : (i == 4) ? 16'h0000 : 16'($urandom));
    end
    push_cmd(CMD_CREATE, 32'd7, 32'd1, 1'b1, 4'd0, 1'b1, 16'h1234);
    push_cmd(CMD_TICK, 32'd20, 32'd0, 1'b0, 4'd0, 1'b0, 16'd0);
    push_cmd(CMD_KILL, 32'd21, 32'd0, 1'b0, 4'd5, 1'b0, 16'd0);
    push_cmd(CMD_RESTART, 32'd22, 32'd0, 1'b0, 4'd3, 1'b0, 16'd0);
    push_cmd(CMD_CREATE, 32'd30, 32'd2, 1'b0, 4'd0, 1'b1, 16'hA5A5);
    push_cmd(CMD_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 4'd0, 1'b0, 16'd0);
    push_cmd(CMD_KILL, 32'd40, 32'd0, 1'b0, 4'd15, 1'b0, 16'd0);
    wait_quiet();

    // random phase at reset time_max, clock starting near the top
    @(negedge clk);
    gen_now = 32'hFFFF_FF00;
    queue_random_cmds(100);
    wait_quiet();

    // random phases over several time_max settings, extremes included
    tmax_set[0] = 32'd0;
    tmax_set[1] = 32'd1000;
    tmax_set[2] = $urandom;
    tmax_set[3] = 32'hFFFF_FFFF;
    for (i = 0; i < 4; i++) begin
      write_time_max(tmax_set[i]);
      @(negedge clk);
      gen_now = 32'(longint'($urandom) % (longint'(tm_max) + 1));
      queue_random_cmds(100);
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (timer_results_due.size() != 0) begin
      report_mismatch("results never seen", 32'd0, 32'(timer_results_due.size()));
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
